[sv/dilated_causal_conv_forward_assert.svh]
// ----------------------------------------------------------------------------
// Dilated causal convolution assertion macros
// Shared concurrent assertion forms, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DILATED_CAUSAL_CONV_FORWARD_ASSERT_SVH
`define DILATED_CAUSAL_CONV_FORWARD_ASSERT_SVH

// same-cycle implication
`define DCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dcc_pkg.sv]
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, sizes and arithmetic helpers for the dilated causal convolution.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int MAX_TAPS      = 8;
	localparam int MAX_SPACING   = 8;
	localparam int MAX_IN        = 16;
	localparam int MAX_OUT       = 16;
	localparam int HISTORY_STEPS = 64;

	localparam int TAP_W  = $clog2(MAX_TAPS);
	localparam int TAPC_W = $clog2(MAX_TAPS + 1);
	localparam int SPC_W  = $clog2(MAX_SPACING + 1);
	localparam int IN_W   = $clog2(MAX_IN);
	localparam int INC_W  = $clog2(MAX_IN + 1);
	localparam int OUT_W  = $clog2(MAX_OUT);
	localparam int OUTC_W = $clog2(MAX_OUT + 1);
	localparam int HIST_W = $clog2(HISTORY_STEPS);
	localparam int BACK_W = TAPC_W + SPC_W;

	localparam int WS_DEPTH   = MAX_TAPS * MAX_IN * MAX_OUT;
	localparam int WS_AW      = $clog2(WS_DEPTH);
	localparam int RING_DEPTH = HISTORY_STEPS * MAX_IN;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	localparam int SLOT_W  = 11;
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 48;
	localparam int PROD_W  = 2 * VALUE_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;
	localparam int QDEPTH     = 2;
	localparam int QIDX_W     = $clog2(QDEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_COUNT   = 3'd0,
		REG_TAP_SPACING = 3'd1,
		REG_IN_CHANNELS = 3'd2,
		REG_OUT_CHANNELS= 3'd3,
		REG_BIAS_ENABLE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_WEIGHT = 2'd0,
		K_BIAS   = 2'd1,
		K_RESID  = 2'd2,
		K_SAMPLE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_ISSUE = 2'd1,
		S_DRAIN = 2'd2,
		S_OUT   = 2'd3
	} bstate_t;

	typedef struct packed {
		kind_t                     kind;
		logic                      hit;
		logic [SLOT_W-1:0]         slot;
		logic signed [VALUE_W-1:0] value;
		logic                      first;
		logic                      done;
		logic                      final_s;
	} item_t;

	function automatic logic signed [SUM_W-1:0] q412_to_q824(
		input logic signed [VALUE_W-1:0] v);
		q412_to_q824 = {{(SUM_W-VALUE_W-12){v[VALUE_W-1]}}, v, 12'b0};
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a, input logic signed [SUM_W-1:0] b);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1])
			sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sat_add = s[SUM_W-1:0];
	endfunction

endpackage

[sv/dcc_ram.sv]
// ----------------------------------------------------------------------------
// dcc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/dcc_front.sv]
// ----------------------------------------------------------------------------
// dcc_front
// Accepts input transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module dcc_front import dcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic [3:0]  s_tuser,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t             ent_q [QDEPTH];
	logic [QIDX_W-1:0] wr_ptr_q;
	logic [QIDX_W-1:0] rd_ptr_q;
	logic [QIDX_W:0]   count_q;
	item_t             new_item;
	logic              push;

	always_comb begin
		new_item.slot    = s_tdata[SLOT_W-1:0];
		new_item.value   = s_tdata[SLOT_W +: VALUE_W];
		new_item.first   = s_tuser[2];
		new_item.done    = s_tlast;
		new_item.final_s = s_tuser[3];
		case (s_tuser[1:0])
			2'd0: begin
				new_item.kind = K_WEIGHT;
				new_item.hit  = int'(s_tdata[SLOT_W-1:0]) < WS_DEPTH;
			end
			2'd1: begin
				new_item.kind = K_BIAS;
				new_item.hit  = int'(s_tdata[SLOT_W-1:0]) < MAX_OUT;
			end
			2'd2: begin
				new_item.kind = K_RESID;
				new_item.hit  = int'(s_tdata[SLOT_W-1:0]) < MAX_OUT;
			end
			default: begin
				new_item.kind = K_SAMPLE;
				new_item.hit  = int'(s_tdata[SLOT_W-1:0]) < MAX_IN;
			end
		endcase
	end

	assign s_tready = int'(count_q) < QDEPTH;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != '0;
	assign q_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QIDX_W+1)'(push) - (QIDX_W+1)'(q_pop);
		end
	end

endmodule

[sv/dcc_back.sv]
// ----------------------------------------------------------------------------
// dcc_back
// Executes queued items: store writes, history writes and the per-step MAC.
// ----------------------------------------------------------------------------
`include "dilated_causal_conv_forward_assert.svh"

module dcc_back import dcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,
	output logic                  m_tlast,
	output logic [0:0]            m_tuser
);

	logic [3:0] tap_count_q, tap_spacing_q;
	logic [4:0] in_channels_q, out_channels_q;
	logic       bias_enable_q;

	logic signed [VALUE_W-1:0] bias_q  [MAX_OUT];
	logic signed [VALUE_W-1:0] resid_q [MAX_OUT];
	logic                      present_q;
	logic [HIST_W-1:0]         ptr_q, steps_q;
	logic                      final_q;

	bstate_t state_q, state_d;
	logic [TAPC_W-1:0] j_q;
	logic [INC_W-1:0]  i_q;
	logic [OUT_W-1:0]  o_q;
	logic signed [SUM_W-1:0] acc_q;

	logic rd_v_s1, prod_v_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic mv_q, mlast_q, mseq_q;
	logic [OUT_W-1:0] mch_q;
	logic signed [SUM_W-1:0] msum_q;

	logic [TAPC_W-1:0] taps;
	logic [SPC_W-1:0]  gap;
	logic [INC_W-1:0]  nin;
	logic [OUTC_W-1:0] nout;
	logic [BACK_W-1:0] back;
	logic              tap_ok, chan_last;
	logic [HIST_W-1:0] row;

	logic pop_sample, issue, out_load, finish, start;
	logic signed [SUM_W-1:0] out_val;
	logic [VALUE_W-1:0] x_rd, w_rd;
	logic [OUT_W-1:0]   next_o;
	logic [HIST_W-1:0]  steps_base;

	assign taps = (int'(tap_count_q) > MAX_TAPS) ? TAPC_W'(MAX_TAPS) : TAPC_W'(tap_count_q);
	assign gap  = (int'(tap_spacing_q) > MAX_SPACING) ? SPC_W'(MAX_SPACING)
		: SPC_W'(tap_spacing_q);
	assign nin  = (int'(in_channels_q) > MAX_IN) ? INC_W'(MAX_IN) : INC_W'(in_channels_q);
	assign nout = (int'(out_channels_q) > MAX_OUT) ? OUTC_W'(MAX_OUT)
		: OUTC_W'(out_channels_q);

	assign back      = BACK_W'(j_q) * BACK_W'(gap);
	assign tap_ok    = (int'(back) <= int'(steps_q)) && (int'(back) < HISTORY_STEPS);
	assign row       = ptr_q - HIST_W'(back);
	assign chan_last = (OUTC_W'(o_q) + 1'b1) == nout;
	assign next_o    = o_q + 1'b1;
	assign out_val   = (final_q && present_q)
		? sat_add(acc_q, q412_to_q824(resid_q[o_q])) : acc_q;
	assign pop_sample = q_pop && (q_item.kind == K_SAMPLE);
	assign steps_base = (pop_sample && q_item.first) ? '0 : steps_q;

	dcc_ram #(.WIDTH(VALUE_W), .DEPTH(WS_DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (q_pop && q_item.kind == K_WEIGHT && q_item.hit),
		.waddr (q_item.slot[WS_AW-1:0]),
		.wdata (q_item.value),
		.raddr ({j_q[TAP_W-1:0], i_q[IN_W-1:0], o_q}),
		.rdata (w_rd)
	);

	dcc_ram #(.WIDTH(VALUE_W), .DEPTH(RING_DEPTH)) u_ring_ram (
		.clk   (clk),
		.we    (pop_sample && q_item.hit),
		.waddr ({ptr_q, q_item.slot[IN_W-1:0]}),
		.wdata (q_item.value),
		.raddr ({row, i_q[IN_W-1:0]}),
		.rdata (x_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid && q_item.kind == K_SAMPLE && q_item.done && nout != '0)
					state_d = S_ISSUE;
			end
			S_ISSUE: begin
				if (j_q >= taps) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!rd_v_s1 && !prod_v_s2) state_d = S_OUT;
			end
			S_OUT: begin
				if (!mv_q || m_tready) state_d = chan_last ? S_IDLE : S_ISSUE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		finish   = 1'b0;
		start    = 1'b0;
		case (state_q)
			S_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_item.kind == K_SAMPLE && q_item.done) begin
					if (nout == '0) finish = 1'b1;
					else start = 1'b1;
				end
			end
			S_ISSUE: issue = (j_q < taps) && tap_ok && (nin != '0);
			S_OUT: begin
				out_load = !mv_q || m_tready;
				finish   = out_load && chan_last;
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q    <= 4'd1;
			tap_spacing_q  <= 4'd1;
			in_channels_q  <= 5'd16;
			out_channels_q <= 5'd16;
			bias_enable_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TAP_COUNT:    tap_count_q    <= cfg_data[3:0];
				REG_TAP_SPACING:  tap_spacing_q  <= cfg_data[3:0];
				REG_IN_CHANNELS:  in_channels_q  <= cfg_data;
				REG_OUT_CHANNELS: out_channels_q <= cfg_data;
				REG_BIAS_ENABLE:  bias_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.kind == K_BIAS && q_item.hit)
			bias_q[q_item.slot[OUT_W-1:0]] <= q_item.value;
		if (q_pop && q_item.kind == K_RESID && q_item.hit)
			resid_q[q_item.slot[OUT_W-1:0]] <= q_item.value;
		if (start) final_q <= q_item.final_s;
		prod_s2 <= $signed(x_rd) * $signed(w_rd);
		if (out_load) begin
			mch_q   <= o_q;
			msum_q  <= out_val;
			mlast_q <= chan_last;
			mseq_q  <= final_q;
		end
		if (start) begin
			o_q   <= '0;
			j_q   <= '0;
			i_q   <= '0;
			acc_q <= bias_enable_q ? q412_to_q824(bias_q[0]) : '0;
		end else if (state_q == S_OUT && out_load && !chan_last) begin
			o_q   <= next_o;
			j_q   <= '0;
			i_q   <= '0;
			acc_q <= bias_enable_q ? q412_to_q824(bias_q[next_o]) : '0;
		end else begin
			if (prod_v_s2)
				acc_q <= sat_add(acc_q, {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2});
			if (state_q == S_ISSUE && j_q < taps) begin
				if (!tap_ok || nin == '0 || i_q + 1'b1 == nin) begin
					j_q <= j_q + 1'b1;
					i_q <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			present_q <= 1'b0;
			ptr_q     <= '0;
			steps_q   <= '0;
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
			mv_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
			if (q_pop && q_item.kind == K_RESID) present_q <= 1'b1;
			if (finish) begin
				ptr_q   <= ptr_q + 1'b1;
				steps_q <= (int'(steps_base) < HISTORY_STEPS - 1) ? steps_base + 1'b1
					: steps_base;
			end else if (pop_sample && q_item.first) begin
				steps_q <= '0;
			end
			if (out_load) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {{(56-SUM_W-OUT_W){1'b0}}, msum_q, mch_q};
	assign m_tlast  = mlast_q;
	assign m_tuser  = mseq_q;

	`DCC_ASSERT_NOW(a_load_free, out_load, !mv_q || m_tready, "result overwrote a held result")
	`DCC_ASSERT_NOW(a_pop_idle, q_pop, state_q == S_IDLE && q_valid, "pop outside idle")
	`DCC_ASSERT_NOW(a_issue_state, rd_v_s1, state_q == S_ISSUE || state_q == S_DRAIN,
		"read in flight outside compute")
	`DCC_ASSERT_NEXT(a_finish_idle, finish, state_q == S_IDLE, "finish did not return to idle")

endmodule

[sv/dilated_causal_conv_forward.sv]
// ----------------------------------------------------------------------------
// dilated_causal_conv_forward
// Multichannel dilated causal 1-D convolution, Q4.12 in, saturated Q24.24 out.
// ----------------------------------------------------------------------------
// Weight, bias, residual and non-final sample transactions pass to the engine
// through a two-entry queue. A sample that closes a time step starts the
// compute: one shared multiply-accumulate unit, fed by the weight RAM and the
// history RAM, does one product per cycle while it issues (a held output
// result stalls the step); up to 2048 products and 16 results with all
// settings at maximum. No input is taken from the queue while a step is
// computed.
module dilated_causal_conv_forward import dcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // slot[10:0], value[26:11]
	input  logic        s_tlast,
	input  logic [3:0]  s_tuser,   // func[1:0], first_step[2], final_step[3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_channel[3:0], conv_sum[51:4]
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // sequence_end[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	dcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	dcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for dilated_causal_conv_forward
// Loads weights, biases and residuals, streams sample steps through several
// register settings, and compares every output against a built-in model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import dcc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // slot[10:0], value[26:11]
	logic        s_tlast = 1'b0;
	logic [3:0]  s_tuser = '0;   // func[1:0], first_step[2], final_step[3]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // out_channel[3:0], conv_sum[51:4]
	logic        m_tlast;
	logic [0:0]  m_tuser;        // sequence_end[0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;

	typedef struct {
		logic [3:0]  chan;
		logic [47:0] sum;
		logic        last;
		logic        seq_end;
	} conv_out_t;

	conv_out_t sum_queue[$];
	int        errors = 0;
	int        cycles = 0;
	bit        stall_free = 1'b0;

	logic signed [15:0] m_weight[WS_DEPTH];
	logic signed [15:0] m_bias[MAX_OUT];
	logic signed [15:0] m_resid[MAX_OUT];
	logic signed [15:0] m_ring[RING_DEPTH];
	bit                 m_resid_on = 1'b0;
	int                 m_ptr = 0;
	int                 m_seen = 0;
	int                 r_taps = 1, r_gap = 1, r_nin = 16, r_nout = 16, r_bias = 1;

	dilated_causal_conv_forward u_top (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic signed [47:0] clamp_add(logic signed [47:0] a,
			longint b);
		longint s;
		s = longint'(a) + b;
		if (s > 64'sh7FFFFFFFFFFF) s = 64'sh7FFFFFFFFFFF;
		if (s < -64'sh800000000000) s = -64'sh800000000000;
		return s[47:0];
	endfunction

	function automatic void predict_conv(kind_t func, int slot, logic signed [15:0] v,
			bit first, bit done, bit fin);
		int taps, gap, nin, nout, back, row;
		logic signed [47:0] acc;
		conv_out_t r;
		case (func)
			K_WEIGHT: if (slot < WS_DEPTH) m_weight[slot] = v;
			K_BIAS: if (slot < MAX_OUT) m_bias[slot] = v;
			K_RESID: begin
				if (slot < MAX_OUT) m_resid[slot] = v;
				m_resid_on = 1'b1;
			end
			default: begin
				if (first) m_seen = 0;
				if (slot < MAX_IN) m_ring[m_ptr * MAX_IN + slot] = v;
				if (done) begin
					taps = r_taps > MAX_TAPS ? MAX_TAPS : r_taps;
					gap = r_gap > MAX_SPACING ? MAX_SPACING : r_gap;
					nin = r_nin > MAX_IN ? MAX_IN : r_nin;
					nout = r_nout > MAX_OUT ? MAX_OUT : r_nout;
					for (int o = 0; o < nout; o++) begin
						acc = r_bias ? 48'(longint'(m_bias[o]) * 4096) : '0;
						for (int j = 0; j < taps; j++) begin
							back = j * gap;
							if (back > m_seen || back >= HISTORY_STEPS) continue;
							row = (m_ptr + HISTORY_STEPS - back) % HISTORY_STEPS;
							for (int i = 0; i < nin; i++)
								acc = clamp_add(acc, longint'(m_ring[row * MAX_IN + i]) *
									longint'(m_weight[(j * MAX_IN + i) * MAX_OUT + o]));
						end
						if (fin && m_resid_on)
							acc = clamp_add(acc, longint'(m_resid[o]) * 4096);
						r.chan = o[3:0];
						r.sum = acc;
						r.last = (o + 1 == nout);
						r.seq_end = fin;
						sum_queue.push_back(r);
					end
					m_ptr = (m_ptr + 1) % HISTORY_STEPS;
					if (m_seen < HISTORY_STEPS - 1) m_seen++;
				end
			end
		endcase
	endfunction

	// random output stall
	always @(posedge clk) begin
		m_tready <= stall_free || ($urandom_range(99) >= 30);
	end

	always @(posedge clk) begin
		conv_out_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (sum_queue.size() == 0) begin
				$error("out_channel exp none got %0d", m_tdata[3:0]);
				errors++;
			end else begin
				e = sum_queue.pop_front();
				if (m_tdata[3:0] !== e.chan) begin
					$error("out_channel exp %0d got %0d", e.chan, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[51:4] !== e.sum) begin
					$error("conv_sum exp %0d got %0d", $signed(e.sum),
						$signed(m_tdata[51:4]));
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_of_step exp %0b got %0b", e.last, m_tlast);
					errors++;
				end
				if (m_tuser[0] !== e.seq_end) begin
					$error("sequence_end exp %0b got %0b", e.seq_end, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	task automatic send_item(kind_t func, int slot, logic signed [15:0] v,
			bit first = 0, bit done = 0, bit fin = 0);
		while (!stall_free && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, v, slot[10:0]};
		s_tuser <= {fin, first, func};
		s_tlast <= done;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_conv(func, slot, v, first, done, fin);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sum_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d[4:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TAP_COUNT: r_taps = d & 15;
			REG_TAP_SPACING: r_gap = d & 15;
			REG_IN_CHANNELS: r_nin = d & 31;
			REG_OUT_CHANNELS: r_nout = d & 31;
			default: r_bias = d & 1;
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(int tc, int sp, int ic, int oc, int be);
		write_reg(REG_TAP_COUNT, tc);
		write_reg(REG_TAP_SPACING, sp);
		write_reg(REG_IN_CHANNELS, ic);
		write_reg(REG_OUT_CHANNELS, oc);
		write_reg(REG_BIAS_ENABLE, be);
	endtask

	// every step writes channels 0..chans-1 so no unwritten history is read
	task automatic run_steps(int steps, int chans, bit fin_last, bit rnd_flags);
		int n;
		bit fin;
		n = (chans < 1) ? 1 : chans;
		for (int t = 0; t < steps; t++) begin
			fin = (fin_last && t == steps - 1) || (rnd_flags && $urandom_range(3) == 0);
			if (rnd_flags && $urandom_range(3) == 0)
				send_item(K_SAMPLE, $urandom_range(2047, MAX_IN), 16'($urandom));
			for (int c = 0; c < n; c++)
				send_item(K_SAMPLE, c, 16'($urandom),
					(t == 0) || (rnd_flags && c == 0 && $urandom_range(7) == 0),
					c == n - 1, fin);
		end
	endtask

	task automatic test_load();
		// taps 0..2 over two inputs and two outputs
		for (int j = 0; j < 3; j++)
			for (int i = 0; i < 2; i++)
				for (int o = 0; o < 2; o++)
					send_item(K_WEIGHT, (j * MAX_IN + i) * MAX_OUT + o,
						(j == 0) ? (((i + o) & 1) ? 16'sh8000 : 16'sh7FFF)
						: 16'($urandom));
		for (int j = 3; j < MAX_TAPS; j++)
			send_item(K_WEIGHT, j * MAX_IN * MAX_OUT, 16'($urandom));
		for (int o = 2; o < MAX_OUT; o++) send_item(K_WEIGHT, o, 16'($urandom));
		send_item(K_BIAS, 0, 16'sh7FFF);
		send_item(K_BIAS, 1, 16'sh8000);
		send_item(K_BIAS, 2047, 16'sh1234);
	endtask

	task automatic test_directed();
		drain_results();
		set_regs(2, 1, 2, 2, 1);
		run_steps(3, 2, 1'b1, 1'b0);
		send_item(K_SAMPLE, 2047, 16'sh7FFF);
		for (int o = 0; o < 2; o++) send_item(K_RESID, o, 16'($urandom));
		send_item(K_RESID, 2047, 16'sh8000);
		run_steps(2, 2, 1'b1, 1'b0);
		send_item(K_SAMPLE, 0, 16'sh8000, 1'b1, 1'b0, 1'b0);
		send_item(K_SAMPLE, 1, 16'sh7FFF, 1'b0, 1'b0, 1'b0);
		send_item(K_SAMPLE, 2047, 16'sh0001, 1'b0, 1'b1, 1'b1);
		drain_results();
	endtask

	task automatic test_settings();
		int tc[6] = '{15, 1, 0, 3, 2, 3};
		int sp[6] = '{0, 1, 1, 1, 1, 15};
		int ic[6] = '{1, 1, 2, 0, 2, 2};
		int oc[6] = '{1, 31, 2, 2, 0, 2};
		int be[6] = '{0, 0, 1, 1, 1, 1};
		int st[6] = '{2, 1, 2, 2, 2, 3};
		bit fl[6] = '{1, 0, 1, 1, 1, 1};
		for (int p = 0; p < 6; p++) begin
			set_regs(tc[p], sp[p], ic[p], oc[p], be[p]);
			run_steps(st[p], ic[p], fl[p], 1'b0);
			drain_results();
		end
	endtask

	task automatic test_random();
		int nin;
		drain_results();
		for (int p = 0; p < 5; p++) begin
			nin = $urandom_range(2, 1);
			set_regs($urandom_range(3, 1), $urandom_range(8, 1), nin,
				$urandom_range(2, 1), $urandom_range(1));
			stall_free = (p == 2);
			run_steps(4, nin, 1'b1, 1'b1);
			if ($urandom_range(1)) send_item(K_RESID, $urandom_range(1), 16'($urandom));
			drain_results();
		end
		stall_free = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load();
		test_directed();
		test_settings();
		test_random();
		drain_results();
		if (errors == 0 && sum_queue.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
